FILE: rtl/crm_pkg.sv
// ----------------------------------------------------------------------------
// Coalescing request mailbox package
// Shared types, action codes and counter indexes for the mailbox block.
// ----------------------------------------------------------------------------
package crm_pkg;

    // Widths fixed by the request format.
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned PAYLOAD_W  = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned STAT_IDX_W = 3;
    localparam int unsigned ACTION_W   = 3;
    localparam int unsigned SLOTS_W    = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned NUM_CNT    = 5;

    // Packed stream widths (whole bytes).
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 104;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_SLOTS = 1'd1;

    // Event counter indexes, as reported through stat_index.
    localparam logic [STAT_IDX_W-1:0] STAT_SUBMITTED = 3'd0;
    localparam logic [STAT_IDX_W-1:0] STAT_MERGED    = 3'd1;
    localparam logic [STAT_IDX_W-1:0] STAT_CANCELLED = 3'd2;
    localparam logic [STAT_IDX_W-1:0] STAT_STALE     = 3'd3;
    localparam logic [STAT_IDX_W-1:0] STAT_COMPLETED = 3'd4;

    // Mailbox actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SUBMIT     = 3'd0,
        ACT_CLAIM      = 3'd1,
        ACT_COMPLETED  = 3'd2,
        ACT_INVALIDATE = 3'd3,
        ACT_DISCARD_Q  = 3'd4,
        ACT_CANCELLED  = 3'd5,
        ACT_STALE      = 3'd6,
        ACT_SET_NOTIFY = 3'd7
    } action_t;

    // One incoming request.
    typedef struct packed {
        action_t                 action;
        logic [PAYLOAD_W-1:0]    payload;
        logic                    offer_bitmap;
        logic                    bitmap_source_ok;
        logic                    offer_native;
        logic                    native_source_ok;
        logic [SEQ_W-1:0]        seq_arg;
        logic                    notify_on;
        logic [STAT_IDX_W-1:0]   stat_index;
    } req_t;

    // One result.
    typedef struct packed {
        logic [SEQ_W-1:0]     seq_out;
        logic                 claimed;
        logic [PAYLOAD_W-1:0] claim_payload;
        logic                 claim_has_bitmap;
        logic                 claim_bitmap_slot;
        logic                 claim_has_native;
        logic                 claim_native_slot;
        logic                 notify;
        logic                 newer;
        logic                 idle;
        logic [CNT_W-1:0]     stat_value;
    } res_t;

endpackage

FILE: rtl/crm_core.sv
// ----------------------------------------------------------------------------
// Coalescing request mailbox core
// Holds the mailbox state and applies one request per step, producing the
// result from the state as it stands after that step.
// ----------------------------------------------------------------------------
module crm_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  crm_pkg::req_t                   req,
    input  logic                            cfg_we,
    input  logic [crm_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [crm_pkg::SLOTS_W-1:0]     cfg_value,
    output crm_pkg::res_t                   res
);
    import crm_pkg::*;

    logic [SLOTS_W-1:0]   bitmap_present_reg;
    logic [SLOTS_W-1:0]   native_present_reg;

    logic [SEQ_W-1:0]     latest_reg,    latest_next;
    logic [SEQ_W-1:0]     completed_reg, completed_next;
    logic [SEQ_W-1:0]     active_reg,    active_next;
    logic [PAYLOAD_W-1:0] payload_reg,   payload_next;
    logic [1:0]           flags_reg,     flags_next;
    logic [1:0]           slots_reg,     slots_next;
    logic                 notify_en_reg, notify_en_next;
    logic [CNT_W-1:0]     cnt_reg  [NUM_CNT];
    logic [CNT_W-1:0]     cnt_next [NUM_CNT];

    logic                 pending;
    logic                 bm_next_slot;
    logic                 nt_next_slot;
    logic                 snap_bitmap;
    logic                 snap_native;

    // Snapshot decision per page kind: the slot after the current one must exist.
    always_comb
    begin
        bm_next_slot = ~slots_reg[0];
        nt_next_slot = ~slots_reg[1];
        snap_bitmap  = req.offer_bitmap & req.bitmap_source_ok &
                       bitmap_present_reg[bm_next_slot];
        snap_native  = req.offer_native & req.native_source_ok &
                       native_present_reg[nt_next_slot];
        pending      = (latest_reg != '0) && (latest_reg != completed_reg) &&
                       (latest_reg != active_reg);
    end

    // Step logic: next state and the action-dependent result fields.
    always_comb
    begin
        latest_next    = latest_reg;
        completed_next = completed_reg;
        active_next    = active_reg;
        payload_next   = payload_reg;
        flags_next     = flags_reg;
        slots_next     = slots_reg;
        notify_en_next = notify_en_reg;
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end

        res.seq_out           = '0;
        res.claimed           = 1'b0;
        res.claim_payload     = '0;
        res.claim_has_bitmap  = 1'b0;
        res.claim_bitmap_slot = 1'b0;
        res.claim_has_native  = 1'b0;
        res.claim_native_slot = 1'b0;
        res.notify            = 1'b0;

        unique case (req.action)
            ACT_SUBMIT:
            begin
                if (latest_reg != completed_reg)
                begin
                    cnt_next[STAT_MERGED] = cnt_reg[STAT_MERGED] + 1'b1;
                end
                latest_next   = latest_reg + 1'b1;
                payload_next  = req.payload;
                flags_next    = {snap_native, snap_bitmap};
                slots_next[0] = snap_bitmap ? bm_next_slot : slots_reg[0];
                slots_next[1] = snap_native ? nt_next_slot : slots_reg[1];
                cnt_next[STAT_SUBMITTED] = cnt_reg[STAT_SUBMITTED] + 1'b1;
                res.notify    = notify_en_reg;
                res.seq_out   = latest_next;
            end
            ACT_CLAIM:
            begin
                if (pending)
                begin
                    active_next           = latest_reg;
                    res.claimed           = 1'b1;
                    res.seq_out           = latest_reg;
                    res.claim_payload     = payload_reg;
                    res.claim_has_bitmap  = flags_reg[0];
                    res.claim_has_native  = flags_reg[1];
                    res.claim_bitmap_slot = flags_reg[0] & slots_reg[0];
                    res.claim_native_slot = flags_reg[1] & slots_reg[1];
                end
            end
            ACT_COMPLETED:
            begin
                completed_next = req.seq_arg;
                active_next    = '0;
                cnt_next[STAT_COMPLETED] = cnt_reg[STAT_COMPLETED] + 1'b1;
            end
            ACT_INVALIDATE:
            begin
                latest_next = completed_reg;
                active_next = '0;
            end
            ACT_DISCARD_Q:
            begin
                if (latest_reg != active_reg)
                begin
                    latest_next = completed_reg;
                end
            end
            ACT_CANCELLED:
            begin
                cnt_next[STAT_CANCELLED] = cnt_reg[STAT_CANCELLED] + 1'b1;
                active_next = '0;
            end
            ACT_STALE:
            begin
                cnt_next[STAT_STALE] = cnt_reg[STAT_STALE] + 1'b1;
                active_next = '0;
            end
            ACT_SET_NOTIFY:
            begin
                notify_en_next = req.notify_on;
                res.notify     = req.notify_on & pending;
            end
            default:
            begin
                latest_next = latest_reg;
            end
        endcase

        // Status flags and the selected counter, all taken after the step.
        res.newer = latest_next > req.seq_arg;
        res.idle  = (active_next == '0) && (latest_next == completed_next);
        unique case (req.stat_index)
            STAT_SUBMITTED: res.stat_value = cnt_next[STAT_SUBMITTED];
            STAT_MERGED:    res.stat_value = cnt_next[STAT_MERGED];
            STAT_CANCELLED: res.stat_value = cnt_next[STAT_CANCELLED];
            STAT_STALE:     res.stat_value = cnt_next[STAT_STALE];
            STAT_COMPLETED: res.stat_value = cnt_next[STAT_COMPLETED];
            default:        res.stat_value = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_present_reg <= '0;
            native_present_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BITMAP_SLOTS: bitmap_present_reg <= cfg_value;
                CFG_NATIVE_SLOTS: native_present_reg <= cfg_value;
                default:          bitmap_present_reg <= bitmap_present_reg;
            endcase
        end
    end

    // Mailbox state, updated once per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg    <= '0;
            completed_reg <= '0;
            active_reg    <= '0;
            payload_reg   <= '0;
            flags_reg     <= '0;
            slots_reg     <= '0;
            notify_en_reg <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            latest_reg    <= latest_next;
            completed_reg <= completed_next;
            active_reg    <= active_next;
            payload_reg   <= payload_next;
            flags_reg     <= flags_next;
            slots_reg     <= slots_next;
            notify_en_reg <= notify_en_next;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A claimed request always carries a live sequence number.
    a_claim_seq: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.claimed |-> res.seq_out != '0)
        else $error("claim returned sequence zero");

    // A claim leaves the claimed request active.
    a_claim_active: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.claimed |=> active_reg == latest_reg)
        else $error("claimed request not marked active");

    // Without a claim no request fields are reported.
    a_noclaim_fields: assert property (@(posedge clk) disable iff (!rst_n)
        step && !res.claimed |-> res.claim_payload == '0 && !res.claim_has_bitmap &&
            !res.claim_has_native)
        else $error("request fields reported without a claim");
`endif

endmodule

FILE: rtl/coalescing_request_mailbox.sv
// ----------------------------------------------------------------------------
// Coalescing request mailbox
// Latest-wins request mailbox with ping-pong page snapshot slots and event
// counters, on streaming request and result channels.
// ----------------------------------------------------------------------------
// Takes one request every clock cycle unless the result register is stalled,
// since each action is only a few compares, increments and register updates,
// and returns exactly one result for each. The request waits in the input
// register; once the result register is free the mailbox state is updated and
// the result lands in the result register, from which it is offered. A
// stalled result register holds the pipeline: while a result waits, the input
// register can still take one request, after which s_axis_tready stays low
// until the result is taken. Configuration writes are taken in any cycle and
// should be issued only while the mailbox is idle.
module coalescing_request_mailbox (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: payload[31:0], offer_bitmap, bitmap_source_ok, offer_native,
    //        native_source_ok, seq_arg[31:0], notify_on, stat_index[2:0]
    input  logic [crm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: action[2:0]
    input  logic [crm_pkg::ACTION_W-1:0]      s_axis_tuser,
    // Result channel.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: seq_out[31:0], claimed, claim_payload[31:0], claim_has_bitmap,
    //        claim_bitmap_slot, claim_has_native, claim_native_slot, notify,
    //        newer, idle, stat_value[31:0]
    output logic [crm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crm_pkg::SLOTS_W-1:0]       cfg_data
);
    import crm_pkg::*;

    logic  in_valid_reg;
    req_t  in_req_reg;
    req_t  in_req;
    logic  out_valid_reg;
    res_t  out_res_reg;
    res_t  core_res;
    logic  out_free;
    logic  step;
    logic  in_fire;

    // Unpack the incoming request.
    always_comb
    begin
        in_req.action           = action_t'(s_axis_tuser);
        in_req.payload          = s_axis_tdata[31:0];
        in_req.offer_bitmap     = s_axis_tdata[32];
        in_req.bitmap_source_ok = s_axis_tdata[33];
        in_req.offer_native     = s_axis_tdata[34];
        in_req.native_source_ok = s_axis_tdata[35];
        in_req.seq_arg          = s_axis_tdata[67:36];
        in_req.notify_on        = s_axis_tdata[68];
        in_req.stat_index       = s_axis_tdata[71:69];
    end

    // Pipeline handshake.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_req_reg <= in_req;
        end
    end

    crm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .req       (in_req_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_value (cfg_data),
        .res       (core_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= core_res;
        end
    end

    // Pack the result.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.stat_value,
                            out_res_reg.idle,
                            out_res_reg.newer,
                            out_res_reg.notify,
                            out_res_reg.claim_native_slot,
                            out_res_reg.claim_has_native,
                            out_res_reg.claim_bitmap_slot,
                            out_res_reg.claim_has_bitmap,
                            out_res_reg.claim_payload,
                            out_res_reg.claimed,
                            out_res_reg.seq_out};

`ifndef NO_ASSERTIONS
    // Backpressure on the request side only when the input and result registers are full.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("request refused with room in the pipeline");

    // A stepped request always yields a result on the next cycle.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped request lost its result");

    // A result slot is never overwritten while it waits to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !step)
        else $error("pending result overwritten");
`endif

endmodule
